@@ src/mqsb_pkg.sv @@
package mqsb_pkg;

	localparam int unsigned ENTRIES_DEF = 1024;
	localparam int unsigned QUEUES_DEF  = 8;
	localparam int unsigned QSEL_W      = 3;
	localparam int unsigned DATA_W      = 32;

	typedef enum logic {
		OP_ENQ = 1'b0,
		OP_DEQ = 1'b1
	} opcode_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_EMPTY = 2'd2
	} status_t;

	// read_data of a refused dequeue
	localparam logic signed [DATA_W-1:0] DATA_NONE = '1;

	typedef struct packed {
		opcode_t                  opcode;
		logic [QSEL_W-1:0]        queue_select;
		logic signed [DATA_W-1:0] write_data;
	} in_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] read_data;
		status_t                  status;
	} out_t;

	// controls from the sequencer to the entry store
	typedef struct packed {
		logic rd_en;
		logic link_we;
		logic data_we;
		logic alloc;
	} mem_ctl_t;

endpackage

@@ src/mqsb_store.sv @@
module mqsb_store #(
	parameter int unsigned ENTRIES = mqsb_pkg::ENTRIES_DEF,
	localparam int unsigned LW = $clog2(ENTRIES),
	localparam int unsigned CW = $clog2(ENTRIES + 1)
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  mqsb_pkg::mem_ctl_t                    ctl,
	input  logic [LW-1:0]                         rd_addr,
	input  logic [LW-1:0]                         link_waddr,
	input  logic [LW-1:0]                         link_wdata,
	input  logic [LW-1:0]                         data_waddr,
	input  logic signed [mqsb_pkg::DATA_W-1:0]    data_wdata,
	input  logic [LW-1:0]                         alloc_idx,
	output logic [LW-1:0]                         link_rdata,
	output logic signed [mqsb_pkg::DATA_W-1:0]    data_rdata
);
	import mqsb_pkg::*;

	logic [LW-1:0]             link_mem [ENTRIES];
	logic signed [DATA_W-1:0]  data_mem [ENTRIES];
	logic [LW-1:0]             link_mem_q;
	logic [LW-1:0]             rd_addr_q;
	logic signed [DATA_W-1:0]  data_mem_q;
	logic [CW-1:0]             hwm_q;
	logic                      fresh_q;
	logic [LW-1:0]             seq_next;

	// single port: a write and a read never share a cycle
	always_ff @(posedge clk) begin
		if (ctl.link_we) begin
			link_mem[link_waddr] <= link_wdata;
		end else if (ctl.rd_en) begin
			link_mem_q <= link_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.data_we) begin
			data_mem[data_waddr] <= data_wdata;
		end else if (ctl.rd_en) begin
			data_mem_q <= data_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			rd_addr_q <= rd_addr;
		end
	end

	// Entries at or above the high-water mark were never handed out, so their
	// link still holds its reset value (index plus one, wrapping).
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hwm_q   <= '0;
			fresh_q <= 1'b0;
		end else begin
			if (ctl.rd_en) begin
				fresh_q <= (CW'(rd_addr) >= hwm_q);
			end
			if (ctl.alloc && (CW'(alloc_idx) == hwm_q)) begin
				hwm_q <= hwm_q + CW'(1);
			end
		end
	end

	assign seq_next   = (rd_addr_q == LW'(ENTRIES - 1)) ? '0 : rd_addr_q + LW'(1);
	assign link_rdata = fresh_q ? seq_next : link_mem_q;
	assign data_rdata = data_mem_q;

	a_alloc_in_order: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.alloc |-> (CW'(alloc_idx) <= hwm_q))
		else $error("allocated entry lies beyond the high-water mark");

	a_single_port: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.link_we |-> !ctl.rd_en)
		else $error("link memory read and written in one cycle");

endmodule

@@ src/mqsb_ctrl.sv @@
module mqsb_ctrl #(
	parameter int unsigned ENTRIES = mqsb_pkg::ENTRIES_DEF,
	parameter int unsigned QUEUES  = mqsb_pkg::QUEUES_DEF,
	localparam int unsigned LW = $clog2(ENTRIES),
	localparam int unsigned CW = $clog2(ENTRIES + 1)
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  mqsb_pkg::in_t                         in_data,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output mqsb_pkg::out_t                        out_data,
	output mqsb_pkg::mem_ctl_t                    ctl,
	output logic [LW-1:0]                         rd_addr,
	output logic [LW-1:0]                         link_waddr,
	output logic [LW-1:0]                         link_wdata,
	output logic [LW-1:0]                         data_waddr,
	output logic signed [mqsb_pkg::DATA_W-1:0]    data_wdata,
	output logic [LW-1:0]                         alloc_idx,
	input  logic [LW-1:0]                         link_rdata,
	input  logic signed [mqsb_pkg::DATA_W-1:0]    data_rdata
);
	import mqsb_pkg::*;

	// only queues that queue_select can reach get storage
	localparam int unsigned QSEL_N = 1 << QSEL_W;
	localparam int unsigned QSTORE = (QUEUES < QSEL_N) ? QUEUES : QSEL_N;
	localparam int unsigned QIW    = (QSTORE > 1) ? $clog2(QSTORE) : 1;

	typedef enum logic [1:0] {
		S_IDLE  = 2'b01,
		S_WRITE = 2'b10
	} state_t;

	state_t                    state_q;
	logic                      out_valid_q;
	out_t                      out_q;
	logic [LW-1:0]             head_q [QSTORE];
	logic [LW-1:0]             tail_q [QSTORE];
	logic [CW-1:0]             cnt_q  [QSTORE];
	logic [LW-1:0]             free_head_q;
	logic [CW-1:0]             free_cnt_q;
	opcode_t                   op_q;
	logic [QIW-1:0]            qi_q;
	logic signed [DATA_W-1:0]  wdata_q;
	logic [LW-1:0]             idx_q;
	logic                      refused_q;

	logic                      accept;
	logic                      fire;
	logic [QIW-1:0]            in_qi;
	logic                      in_oor;
	logic                      in_refused;
	logic [LW-1:0]             link_next;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign fire     = (state_q == S_WRITE) && (!out_valid_q || out_ready);

	assign in_qi  = in_data.queue_select[QIW-1:0];
	assign in_oor = (9'(in_data.queue_select) >= 9'(QUEUES));

	always_comb begin
		if (in_data.opcode == OP_ENQ) begin
			in_refused = in_oor || (free_cnt_q == '0);
			rd_addr    = free_head_q;
		end else begin
			in_refused = in_oor || (cnt_q[in_qi] == '0);
			rd_addr    = head_q[in_qi];
		end
	end

	// links read back are clamped into the store
	assign link_next = (CW'(link_rdata) < CW'(ENTRIES)) ? link_rdata : '0;

	always_comb begin
		ctl.rd_en   = accept;
		ctl.data_we = fire && !refused_q && (op_q == OP_ENQ);
		ctl.alloc   = ctl.data_we;
		ctl.link_we = fire && !refused_q
			&& ((op_q == OP_DEQ) || (cnt_q[qi_q] != '0));
		if (op_q == OP_ENQ) begin
			link_waddr = tail_q[qi_q];
			link_wdata = idx_q;
		end else begin
			link_waddr = idx_q;
			link_wdata = free_head_q;
		end
	end

	assign data_waddr = idx_q;
	assign data_wdata = wdata_q;
	assign alloc_idx  = idx_q;

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q      <= in_data.opcode;
			qi_q      <= in_qi;
			wdata_q   <= in_data.write_data;
			idx_q     <= rd_addr;
			refused_q <= in_refused;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			unique case ({op_q == OP_DEQ, refused_q})
				2'b00: begin
					out_q.read_data <= '0;
					out_q.status    <= STAT_OK;
				end
				2'b01: begin
					out_q.read_data <= '0;
					out_q.status    <= STAT_FULL;
				end
				2'b10: begin
					out_q.read_data <= data_rdata;
					out_q.status    <= STAT_OK;
				end
				default: begin
					out_q.read_data <= DATA_NONE;
					out_q.status    <= STAT_EMPTY;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			free_head_q <= '0;
			free_cnt_q  <= CW'(ENTRIES);
			for (int i = 0; i < QSTORE; i++) begin
				head_q[i] <= '0;
				tail_q[i] <= '0;
				cnt_q[i]  <= '0;
			end
		end else begin
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_WRITE;
					end
				end
				S_WRITE: begin
					if (fire) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			if (fire && !refused_q) begin
				if (op_q == OP_ENQ) begin
					free_head_q <= link_next;
					free_cnt_q  <= free_cnt_q - CW'(1);
					if (cnt_q[qi_q] == '0) begin
						head_q[qi_q] <= idx_q;
					end
					tail_q[qi_q] <= idx_q;
					cnt_q[qi_q]  <= cnt_q[qi_q] + CW'(1);
				end else begin
					head_q[qi_q] <= link_next;
					cnt_q[qi_q]  <= cnt_q[qi_q] - CW'(1);
					free_head_q  <= idx_q;
					free_cnt_q   <= free_cnt_q + CW'(1);
				end
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_refused_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && refused_q) |-> (!ctl.link_we && !ctl.data_we))
		else $error("refused item wrote the store");

	a_accept_to_write: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == S_WRITE))
		else $error("accepted item did not reach the write step");

	a_fire_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> out_valid_q)
		else $error("finished item produced no result");

	a_free_bound: assert property (@(posedge clk) disable iff (!arst_n)
		free_cnt_q <= CW'(ENTRIES))
		else $error("free count exceeds store size");

endmodule

@@ src/multi_queue_shared_buffer_unit.sv @@
// channel   dir   handshake              payload
// in        in    in_valid / in_ready    in_data  (opcode, queue_select, write_data)
// out       out   out_valid / out_ready  out_data (read_data, status)
//
// The link memory's single port is read in the accept cycle and written in
// the write step that follows, when the result is registered.
// in_ready is high only between items; a result waiting in the output
// register holds the write step until out_ready frees it.
// No clearing pass after reset: a high-water mark supplies the initial links.
// Refused items also pass through the write step and leave the queue state unchanged.
module multi_queue_shared_buffer_unit #(
	parameter int unsigned ENTRIES = mqsb_pkg::ENTRIES_DEF,
	parameter int unsigned QUEUES  = mqsb_pkg::QUEUES_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  mqsb_pkg::in_t  in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output mqsb_pkg::out_t out_data
);
	import mqsb_pkg::*;

	localparam int unsigned LW = $clog2(ENTRIES);

	mem_ctl_t                  ctl;
	logic [LW-1:0]             rd_addr;
	logic [LW-1:0]             link_waddr;
	logic [LW-1:0]             link_wdata;
	logic [LW-1:0]             data_waddr;
	logic signed [DATA_W-1:0]  data_wdata;
	logic [LW-1:0]             alloc_idx;
	logic [LW-1:0]             link_rdata;
	logic signed [DATA_W-1:0]  data_rdata;

	mqsb_ctrl #(
		.ENTRIES (ENTRIES),
		.QUEUES  (QUEUES)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data),
		.ctl        (ctl),
		.rd_addr    (rd_addr),
		.link_waddr (link_waddr),
		.link_wdata (link_wdata),
		.data_waddr (data_waddr),
		.data_wdata (data_wdata),
		.alloc_idx  (alloc_idx),
		.link_rdata (link_rdata),
		.data_rdata (data_rdata)
	);

	mqsb_store #(
		.ENTRIES (ENTRIES)
	) u_store (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.rd_addr    (rd_addr),
		.link_waddr (link_waddr),
		.link_wdata (link_wdata),
		.data_waddr (data_waddr),
		.data_wdata (data_wdata),
		.alloc_idx  (alloc_idx),
		.link_rdata (link_rdata),
		.data_rdata (data_rdata)
	);

endmodule

@@ tb/multi_queue_shared_buffer_unit_test.sv @@
module multi_queue_shared_buffer_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	import mqsb_pkg::*;

	localparam int unsigned ENTRIES     = ENTRIES_DEF;
	localparam int unsigned QUEUES      = QUEUES_DEF;
	localparam int unsigned IDX_W       = $clog2(ENTRIES);
	localparam int unsigned IDLE_LIMIT  = 2000;
	localparam int unsigned HOLD_AT     = 300;
	localparam int unsigned HOLD_CYCLES = 400;

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [IDX_W:0]   cnt_t;

	typedef struct {
		in_t  item;
		bit   typed;
		out_t want;
	} stim_row_t;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic in_valid  = 1'b0;
	logic in_ready;
	in_t  in_data   = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_t out_data;

	// shadow of the shared store
	logic [DATA_W-1:0] store_data [ENTRIES];
	idx_t              store_link [ENTRIES];
	idx_t              q_head [QUEUES];
	idx_t              q_tail [QUEUES];
	cnt_t              q_count [QUEUES];
	idx_t              free_head;
	cnt_t              free_left;

	out_t       pending_results [$];
	stim_row_t  directed_rows [$];
	int unsigned mismatches = 0;
	int unsigned items_sent = 0;
	int unsigned n_enq_ok = 0, n_deq_ok = 0, n_full = 0, n_empty = 0;
	bit          tx_burst = 1'b0;

	multi_queue_shared_buffer_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	always #2 clk = ~clk;

	function automatic out_t predict_buffer_op(in_t it);
		out_t        r;
		idx_t        slot;
		int unsigned qn;
		qn = it.queue_select;
		r.read_data = '0;
		r.status = STAT_OK;
		if (it.opcode == OP_ENQ) begin
			if (qn >= QUEUES || free_left == 0) begin
				r.status = STAT_FULL;
			end else begin
				slot = free_head;
				free_head = store_link[slot];
				free_left--;
				if (q_count[qn] == 0)
					q_head[qn] = slot;
				else
					store_link[q_tail[qn]] = slot;
				q_tail[qn] = slot;
				q_count[qn]++;
				store_data[slot] = it.write_data;
			end
		end else begin
			if (qn >= QUEUES || q_count[qn] == 0) begin
				r.status = STAT_EMPTY;
				r.read_data = DATA_NONE;
			end else begin
				slot = q_head[qn];
				q_head[qn] = store_link[slot];
				q_count[qn]--;
				// freed entry goes back on top of the free list
				store_link[slot] = free_head;
				free_head = slot;
				free_left++;
				r.read_data = store_data[slot];
			end
		end
		return r;
	endfunction

	function automatic in_t draw_item(int unsigned enq_pct);
		in_t it;
		it.opcode = ($urandom_range(0, 99) < enq_pct) ? OP_ENQ : OP_DEQ;
		it.queue_select = QSEL_W'($urandom_range(0, QUEUES - 1));
		it.write_data = $urandom();
		return it;
	endfunction

	task automatic add_row(opcode_t op, int unsigned qn, logic [DATA_W-1:0] wd,
			bit typed, logic [DATA_W-1:0] rd, status_t st);
		stim_row_t row;
		row.item.opcode = op;
		row.item.queue_select = QSEL_W'(qn);
		row.item.write_data = wd;
		row.typed = typed;
		row.want.read_data = rd;
		row.want.status = st;
		directed_rows.insert(directed_rows.size(), row);
	endtask

	task automatic send_item(in_t it, bit typed, out_t want);
		int unsigned gap;
		out_t        guess;
		if (items_sent % 40 == 0)
			tx_burst = ($urandom_range(0, 3) == 0);
		gap = tx_burst ? 0 : $urandom_range(0, 15);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (!in_ready);
		guess = predict_buffer_op(it);
		pending_results.insert(pending_results.size(), typed ? want : guess);
		items_sent++;
		case (guess.status)
			STAT_FULL:  n_full++;
			STAT_EMPTY: n_empty++;
			default: begin
				if (it.opcode == OP_ENQ)
					n_enq_ok++;
				else
					n_deq_ok++;
			end
		endcase
	endtask

	task automatic report_mismatch(string what, logic [DATA_W-1:0] got,
			logic [DATA_W-1:0] want);
		$display("%0t ns: %s: got %h, expected %h", $realtime, what, got, want);
		mismatches++;
	endtask

	always @(posedge clk) begin : check_results
		out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("result with no item pending", out_data.read_data, '0);
			end else begin
				want = pending_results[0];
				pending_results.delete(0);
				if (out_data.read_data !== want.read_data)
					report_mismatch("read_data", out_data.read_data, want.read_data);
				if (out_data.status !== want.status)
					report_mismatch("status", 32'(out_data.status), 32'(want.status));
			end
		end
	end

	initial begin : result_side
		int unsigned wait_n;
		int unsigned taken;
		bit          rx_burst;
		bit          held;
		taken = 0;
		rx_burst = 1'b0;
		held = 1'b0;
		@(posedge arst_n);
		forever begin
			if (taken % 50 == 0)
				rx_burst = ($urandom_range(0, 3) == 0);
			wait_n = rx_burst ? 0 : $urandom_range(0, 15);
			// one long hold-off so the block backs up into its input
			if (taken == HOLD_AT && !held) begin
				wait_n = HOLD_CYCLES;
				held = 1'b1;
			end
			if (wait_n != 0) begin
				out_ready <= 1'b0;
				repeat (wait_n) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!(out_valid && out_ready));
			taken++;
		end
	end

	initial begin : watchdog
		int unsigned idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("no handshake for %0d cycles", IDLE_LIMIT);
		$display("multi_queue_shared_buffer_unit: mismatch");
		$finish;
	end

	initial begin : feed_side
		out_t none;
		int unsigned refill_seen;
		none = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			store_data[i] = '0;
			store_link[i] = idx_t'((i + 1) % ENTRIES);
		end
		for (int i = 0; i < QUEUES; i++) begin
			q_head[i] = '0;
			q_tail[i] = '0;
			q_count[i] = '0;
		end
		free_head = '0;
		free_left = cnt_t'(ENTRIES);

		//      op      q  write_data     typed rd            status
		add_row(OP_DEQ, 0, 32'h0000_0000, 1, 32'hFFFF_FFFF, STAT_EMPTY);
		add_row(OP_DEQ, 7, 32'hFFFF_FFFF, 1, 32'hFFFF_FFFF, STAT_EMPTY);
		add_row(OP_ENQ, 7, 32'h7FFF_FFFF, 1, 32'h0000_0000, STAT_OK);
		add_row(OP_ENQ, 7, 32'h8000_0000, 1, 32'h0000_0000, STAT_OK);
		add_row(OP_ENQ, 7, 32'hFFFF_FFFF, 1, 32'h0000_0000, STAT_OK);
		add_row(OP_ENQ, 0, 32'h0000_0000, 1, 32'h0000_0000, STAT_OK);
		add_row(OP_DEQ, 7, 32'h1234_5678, 1, 32'h7FFF_FFFF, STAT_OK);
		add_row(OP_DEQ, 7, 32'h0000_0000, 1, 32'h8000_0000, STAT_OK);
		add_row(OP_DEQ, 7, 32'h0000_0000, 1, 32'hFFFF_FFFF, STAT_OK);
		add_row(OP_DEQ, 7, 32'h0000_0000, 1, 32'hFFFF_FFFF, STAT_EMPTY);
		add_row(OP_DEQ, 0, 32'h0000_0000, 1, 32'h0000_0000, STAT_OK);
		add_row(OP_ENQ, 1, 32'h1111_0001, 0, '0, STAT_OK);
		add_row(OP_ENQ, 2, 32'h2222_0002, 0, '0, STAT_OK);
		add_row(OP_ENQ, 3, 32'h3333_0003, 0, '0, STAT_OK);
		add_row(OP_ENQ, 4, 32'h4444_0004, 0, '0, STAT_OK);
		add_row(OP_ENQ, 5, 32'h5555_0005, 0, '0, STAT_OK);
		add_row(OP_ENQ, 6, 32'h6666_0006, 0, '0, STAT_OK);
		add_row(OP_ENQ, 3, 32'h3333_0013, 0, '0, STAT_OK);
		add_row(OP_DEQ, 6, 32'h0000_0000, 0, '0, STAT_OK);
		add_row(OP_DEQ, 3, 32'h0000_0000, 0, '0, STAT_OK);
		add_row(OP_DEQ, 3, 32'h0000_0000, 0, '0, STAT_OK);
		// tail link is stale here; count alone must say empty
		add_row(OP_DEQ, 3, 32'h0000_0000, 1, 32'hFFFF_FFFF, STAT_EMPTY);
		add_row(OP_ENQ, 5, 32'hA5A5_5A5A, 0, '0, STAT_OK);
		add_row(OP_DEQ, 5, 32'h0000_0000, 0, '0, STAT_OK);
		add_row(OP_DEQ, 1, 32'h0000_0000, 0, '0, STAT_OK);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i])
			send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);

		// mixed traffic, plenty of empty-queue dequeues
		repeat (200) send_item(draw_item(55), 1'b0, none);
		// fill the whole store, then push against full with a few frees between
		while (free_left != 0)
			send_item(draw_item(97), 1'b0, none);
		refill_seen = n_full;
		repeat (16) send_item(draw_item(75), 1'b0, none);
		// drain part of it back out
		repeat (200) send_item(draw_item(15), 1'b0, none);
		in_valid <= 1'b0;

		while (pending_results.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);

		$display("%0d items: %0d stored, %0d returned, %0d refused as full, %0d refused as empty",
			items_sent, n_enq_ok, n_deq_ok, n_full, n_empty);
		$display("store driven to capacity (%0d full refusals after filling), output held %0d cycles",
			n_full - refill_seen, HOLD_CYCLES);
		if (mismatches == 0)
			$display("multi_queue_shared_buffer_unit: match");
		else
			$display("multi_queue_shared_buffer_unit: mismatch");
		$finish;
	end

endmodule

@@ files.f @@
src/mqsb_pkg.sv
src/mqsb_store.sv
src/mqsb_ctrl.sv
src/multi_queue_shared_buffer_unit.sv
tb/multi_queue_shared_buffer_unit_test.sv
